FILE: rtl/midi_channel_duplicator_defines.svh
// Assertion macros used by the MIDI channel duplicator back end.
`ifndef MIDI_CHANNEL_DUPLICATOR_DEFINES_SVH
`define MIDI_CHANNEL_DUPLICATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MDUP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MDUP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mdup_pkg.sv
// Shared types and constants of the MIDI channel duplicator.
package mdup_pkg;

  // Channels generated, 1 to 16; mask bits above this are kept but never used.
  localparam int NUM_CHANNELS = 16;
  // Width of the channel number in the status nibble.
  localparam int CH_W = 4;

  // Job queue between front and back; depth must be a power of two.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [7:0]  STATUS_CHAN_LO   = 8'h80;
  localparam logic [7:0]  STATUS_CHAN_HI   = 8'hEF;
  localparam logic [3:0]  STATUS_CC_NIB    = 4'hB;
  localparam logic [7:0]  CC_ALL_NOTES_OFF = 8'd123;
  localparam logic [7:0]  CC_ALL_SOUND_OFF = 8'd120;
  localparam logic [1:0]  PANIC_BYTES      = 2'd3;
  localparam logic [15:0] MASK_ALL_ONES    = 16'hFFFF;

  typedef enum logic [1:0] {
    JOB_PASS,
    JOB_DUP,
    JOB_PANIC
  } job_kind_t;

  typedef struct packed {
    job_kind_t                 kind;
    logic [7:0]                status;
    logic [7:0]                data_one;
    logic [7:0]                data_two;
    logic [1:0]                byte_count;
    logic [15:0]               offset;
    logic [NUM_CHANNELS-1:0]   chans;
  } job_t;

endpackage

FILE: rtl/mdup_front.sv
// Front end: accepts transactions, keeps the masks and turns each item into a job.
module mdup_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                mask_write,
  input  logic [15:0]         channel_mask,
  input  logic                push,
  input  logic                command,
  input  logic [7:0]          status_byte,
  input  logic [7:0]          data_one,
  input  logic [7:0]          data_two,
  input  logic [1:0]          byte_count,
  input  logic [15:0]         sample_offset,
  input  logic                queue_full,
  output logic                job_push,
  output mdup_pkg::job_t      job
);

  logic [15:0] cfg_mask;
  logic [15:0] applied_mask;

  logic                              accept;
  logic                              chan_msg;
  logic                              job_needed;
  logic [15:0]                       gone;
  logic [mdup_pkg::NUM_CHANNELS-1:0] chans_dup;
  logic [mdup_pkg::NUM_CHANNELS-1:0] chans_gone;

  assign accept     = push && !queue_full;
  assign gone       = applied_mask & ~cfg_mask;
  assign chans_dup  = cfg_mask[mdup_pkg::NUM_CHANNELS-1:0];
  assign chans_gone = gone[mdup_pkg::NUM_CHANNELS-1:0];
  assign chan_msg   = (byte_count != 2'd0) &&
                      (status_byte >= mdup_pkg::STATUS_CHAN_LO) &&
                      (status_byte <= mdup_pkg::STATUS_CHAN_HI);

  always_comb begin
    // zero the bytes the count does not cover
    job.status     = (byte_count != 2'd0) ? status_byte : 8'd0;
    job.data_one   = (byte_count >= 2'd2) ? data_one : 8'd0;
    job.data_two   = (byte_count == 2'd3) ? data_two : 8'd0;
    job.byte_count = byte_count;
    job.offset     = sample_offset;
    if (command) begin
      job.kind   = mdup_pkg::JOB_PANIC;
      job.chans  = chans_gone;
      job_needed = (chans_gone != '0);
    end else if (chan_msg) begin
      job.kind   = mdup_pkg::JOB_DUP;
      job.chans  = chans_dup;
      job_needed = (chans_dup != '0);
    end else begin
      job.kind   = mdup_pkg::JOB_PASS;
      job.chans  = chans_dup;
      job_needed = (cfg_mask != 16'd0);
    end
  end

  assign job_push = accept && job_needed;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_mask     <= mdup_pkg::MASK_ALL_ONES;
      applied_mask <= mdup_pkg::MASK_ALL_ONES;
    end else if (mask_write) begin
      cfg_mask     <= channel_mask;
      applied_mask <= mdup_pkg::MASK_ALL_ONES;
    end else if (accept && command) begin
      applied_mask <= cfg_mask;
    end
  end

endmodule

FILE: rtl/mdup_job_queue.sv
// Short job queue that decouples the front end from the result generator.
module mdup_job_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  mdup_pkg::job_t    wr_job,
  input  logic              rd_en,
  output mdup_pkg::job_t    head,
  output logic              queue_empty,
  output logic              queue_full
);

  mdup_pkg::job_t                entries [mdup_pkg::QUEUE_DEPTH];
  logic [mdup_pkg::QPTR_W-1:0]   wr_ptr;
  logic [mdup_pkg::QPTR_W-1:0]   rd_ptr;
  logic [mdup_pkg::QPTR_W:0]     count;

  assign head        = entries[rd_ptr];
  assign queue_empty = (count == '0);
  assign queue_full  = (count == (mdup_pkg::QPTR_W+1)'(mdup_pkg::QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/mdup_back.sv
// Back end: walks each job's channels; one result per cycle unless stalled.
`include "midi_channel_duplicator_defines.svh"

module mdup_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              queue_empty,
  input  mdup_pkg::job_t    head,
  output logic              queue_pop,
  input  logic              pop,
  output logic              empty,
  output logic [7:0]        out_status,
  output logic [7:0]        out_data_one,
  output logic [7:0]        out_data_two,
  output logic [1:0]        out_byte_count,
  output logic [15:0]       out_offset,
  output logic              last
);

  mdup_pkg::job_t                    cur;
  logic                              cur_valid;
  logic [mdup_pkg::NUM_CHANNELS-1:0] rem;
  logic                              phase;
  logic                              out_valid;

  logic                              out_ready;
  logic                              step;
  logic                              done;
  logic                              load;
  logic [mdup_pkg::CH_W-1:0]         low_idx;
  logic [mdup_pkg::NUM_CHANNELS-1:0] rem_clr;
  logic [7:0]                        res_status;
  logic [7:0]                        res_data_one;
  logic [7:0]                        res_data_two;
  logic [1:0]                        res_byte_count;
  logic [15:0]                       res_offset;

  assign empty     = !out_valid;
  assign out_ready = !out_valid || pop;
  assign step      = cur_valid && out_ready;
  assign rem_clr   = rem & (rem - 1'b1);

  // lowest channel still to visit
  always_comb begin
    low_idx = '0;
    for (int i = mdup_pkg::NUM_CHANNELS - 1; i >= 0; i--) begin
      if (rem[i]) low_idx = mdup_pkg::CH_W'(i);
    end
  end

  always_comb begin
    res_status     = cur.status;
    res_data_one   = cur.data_one;
    res_data_two   = cur.data_two;
    res_byte_count = cur.byte_count;
    res_offset     = cur.offset;
    done           = 1'b1;
    unique case (cur.kind)
      mdup_pkg::JOB_DUP: begin
        res_status = {cur.status[7:4], low_idx};
        done       = (rem_clr == '0);
      end
      mdup_pkg::JOB_PANIC: begin
        res_status     = {mdup_pkg::STATUS_CC_NIB, low_idx};
        res_data_one   = phase ? mdup_pkg::CC_ALL_SOUND_OFF : mdup_pkg::CC_ALL_NOTES_OFF;
        res_data_two   = 8'd0;
        res_byte_count = mdup_pkg::PANIC_BYTES;
        res_offset     = 16'd0;
        done           = phase && (rem_clr == '0);
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  // take the next job as soon as the current one hands over its final result
  assign load      = (!cur_valid || (step && done)) && !queue_empty;
  assign queue_pop = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (load) begin
      cur       <= head;
      rem       <= head.chans;
      phase     <= 1'b0;
      cur_valid <= 1'b1;
    end else if (step && done) begin
      cur_valid <= 1'b0;
    end else if (step) begin
      if ((cur.kind == mdup_pkg::JOB_PANIC) && !phase) begin
        phase <= 1'b1;
      end else begin
        rem   <= rem_clr;
        phase <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid      <= 1'b1;
      out_status     <= res_status;
      out_data_one   <= res_data_one;
      out_data_two   <= res_data_two;
      out_byte_count <= res_byte_count;
      out_offset     <= res_offset;
      last           <= done;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  `MDUP_ASSERT_IMP(a_pop_nonempty, clk, rst, queue_pop, !queue_empty, "job queue popped while empty")
  `MDUP_ASSERT_IMP(a_rem_live, clk, rst, cur_valid && (cur.kind != mdup_pkg::JOB_PASS), rem != '0, "active job has no channel left")
  `MDUP_ASSERT_NXT(a_hold_job, clk, rst, step && !done, cur_valid, "job dropped before its final result")
  `MDUP_ASSERT_NXT(a_free_job, clk, rst, step && done && queue_empty, !cur_valid, "finished job still active")

endmodule

FILE: rtl/midi_channel_duplicator.sv
// Top level of the MIDI channel duplicator: front end, job queue and result generator.
//
// Channel voice messages (status 0x80 to 0xEF) come out once per channel set in
// channel_mask, with the channel nibble rewritten and in ascending channel order;
// any other message comes out once unchanged, and nothing comes out while the mask
// is zero. A block start (command 1) emits All Notes Off and then All Sound Off,
// offset zero, on every channel that was on at the previous block start and is off
// now, then records the current mask. Writing channel_mask marks every channel as
// previously on. Both sides behave as queues: a transaction is taken when push is
// high and full is low, and a result leaves when pop is high and empty is low; last
// flags the final result of each input. The result generator produces one result
// per cycle while the output is not stalled. An input causes one result if it is
// a pass-through message, one per selected channel for a channel message (up to
// 16), and two per released channel for a block start (up to 32). Inputs with no
// result cost no generator time. A four-deep job queue lets input transactions
// keep flowing while the generator works or the output is stalled.
module midi_channel_duplicator (
  input  logic         clk,
  input  logic         rst,
  input  logic         mask_write,
  input  logic [15:0]  channel_mask,
  input  logic         push,
  output logic         full,
  input  logic         command,
  input  logic [7:0]   status_byte,
  input  logic [7:0]   data_one,
  input  logic [7:0]   data_two,
  input  logic [1:0]   byte_count,
  input  logic [15:0]  sample_offset,
  output logic         empty,
  input  logic         pop,
  output logic [7:0]   out_status,
  output logic [7:0]   out_data_one,
  output logic [7:0]   out_data_two,
  output logic [1:0]   out_byte_count,
  output logic [15:0]  out_offset,
  output logic         last
);

  mdup_pkg::job_t  new_job;
  mdup_pkg::job_t  head_job;
  logic            job_push;
  logic            job_pop;
  logic            queue_empty;
  logic            queue_full;

  // Input side stalls only when the job queue is full.
  assign full = queue_full;

  // Classify each transaction and keep the channel masks.
  mdup_front u_front (
    .clk           (clk),
    .rst           (rst),
    .mask_write    (mask_write),
    .channel_mask  (channel_mask),
    .push          (push),
    .command       (command),
    .status_byte   (status_byte),
    .data_one      (data_one),
    .data_two      (data_two),
    .byte_count    (byte_count),
    .sample_offset (sample_offset),
    .queue_full    (queue_full),
    .job_push      (job_push),
    .job           (new_job)
  );

  // Hold jobs until the generator is free.
  mdup_job_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (job_push),
    .wr_job      (new_job),
    .rd_en       (job_pop),
    .head        (head_job),
    .queue_empty (queue_empty),
    .queue_full  (queue_full)
  );

  // Expand jobs into results in the output register, one per cycle unless stalled.
  mdup_back u_back (
    .clk            (clk),
    .rst            (rst),
    .queue_empty    (queue_empty),
    .head           (head_job),
    .queue_pop      (job_pop),
    .pop            (pop),
    .empty          (empty),
    .out_status     (out_status),
    .out_data_one   (out_data_one),
    .out_data_two   (out_data_two),
    .out_byte_count (out_byte_count),
    .out_offset     (out_offset),
    .last           (last)
  );

endmodule

FILE: bench/midi_channel_duplicator_test.sv
// Self-checking testbench for the MIDI channel duplicator: directed, backpressure and random tests.
module midi_channel_duplicator_test;

  // Input item kinds.
  localparam logic CMD_MESSAGE     = 1'b0;
  localparam logic CMD_BLOCK_START = 1'b1;

  // Cycles to let the job queue settle after the last expected result; items
  // that cause no result never enter the four-deep queue.
  localparam int SETTLE_CYCLES   = 16;
  // Length of the long receiver hold-off that fills the block up.
  localparam int HOLD_OFF_CYCLES = 300;
  // Cycles with no transaction on any port before the run is declared hung.
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int MAX_REPORTS     = 10;
  localparam int RANDOM_PHASES   = 6;
  localparam int PHASE_ITEMS     = 12;

  typedef struct packed {
    logic [7:0]  status;
    logic [7:0]  data_one;
    logic [7:0]  data_two;
    logic [1:0]  byte_count;
    logic [15:0] offset;
    logic        last;
  } midi_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        mask_write = 1'b0;
  logic [15:0] channel_mask = mdup_pkg::MASK_ALL_ONES;
  logic        push = 1'b0;
  logic        full;
  logic        command = CMD_MESSAGE;
  logic [7:0]  status_byte = 8'h00;
  logic [7:0]  data_one = 8'h00;
  logic [7:0]  data_two = 8'h00;
  logic [1:0]  byte_count = 2'd0;
  logic [15:0] sample_offset = 16'h0000;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_status;
  logic [7:0]  out_data_one;
  logic [7:0]  out_data_two;
  logic [1:0]  out_byte_count;
  logic [15:0] out_offset;
  logic        last;

  // Shadow copy of the block's mask register and the mask applied at the last block start.
  logic [15:0]  mask_model = mdup_pkg::MASK_ALL_ONES;
  logic [15:0]  applied_model = mdup_pkg::MASK_ALL_ONES;
  // Results still owed by the block, oldest first.
  midi_result_t pending_results[$];
  midi_result_t seen_result;
  midi_result_t want_result;

  int failures = 0;
  int stall_cycles = 0;

  // Sender burst control; a steady sender never idles between items.
  int burst_left = 4;
  bit sender_steady = 1'b0;

  // Receiver stall pattern and the long hold-off request.
  bit hold_req = 1'b0;
  int hold_left = 0;
  int pop_mode = 0;
  int pop_mode_left = 0;

  midi_channel_duplicator dut (
    .clk            (clk),
    .rst            (rst),
    .mask_write     (mask_write),
    .channel_mask   (channel_mask),
    .push           (push),
    .full           (full),
    .command        (command),
    .status_byte    (status_byte),
    .data_one       (data_one),
    .data_two       (data_two),
    .byte_count     (byte_count),
    .sample_offset  (sample_offset),
    .empty          (empty),
    .pop            (pop),
    .out_status     (out_status),
    .out_data_one   (out_data_one),
    .out_data_two   (out_data_two),
    .out_byte_count (out_byte_count),
    .out_offset     (out_offset),
    .last           (last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Build one emitted message; bytes beyond the byte count read as zero.
  function automatic midi_result_t make_result(input logic [7:0] st, input logic [7:0] d1,
                                               input logic [7:0] d2, input logic [1:0] cnt,
                                               input logic [15:0] off);
    midi_result_t r;
    r.status     = (cnt >= 2'd1) ? st : 8'h00;
    r.data_one   = (cnt >= 2'd2) ? d1 : 8'h00;
    r.data_two   = (cnt == 2'd3) ? d2 : 8'h00;
    r.byte_count = cnt;
    r.offset     = off;
    r.last       = 1'b0;
    return r;
  endfunction

  // Work out the messages one accepted item causes and queue them.
  function automatic void predict_duplicates(input logic cmd, input logic [7:0] st,
                                             input logic [7:0] d1, input logic [7:0] d2,
                                             input logic [1:0] cnt, input logic [15:0] off);
    midi_result_t batch[$];
    logic [15:0]  released;
    if (cmd == CMD_BLOCK_START) begin
      // Panic every channel that was on at the last check and is off now.
      released = applied_model & ~mask_model;
      for (int ch = 0; ch < mdup_pkg::NUM_CHANNELS; ch++) begin
        if (released[ch]) begin
          batch.push_back(make_result({mdup_pkg::STATUS_CC_NIB, 4'(ch)},
                                      mdup_pkg::CC_ALL_NOTES_OFF, 8'h00,
                                      mdup_pkg::PANIC_BYTES, 16'h0000));
          batch.push_back(make_result({mdup_pkg::STATUS_CC_NIB, 4'(ch)},
                                      mdup_pkg::CC_ALL_SOUND_OFF, 8'h00,
                                      mdup_pkg::PANIC_BYTES, 16'h0000));
        end
      end
      applied_model = mask_model;
    end else if (mask_model != 16'h0000) begin
      if (cnt != 2'd0 && st >= mdup_pkg::STATUS_CHAN_LO && st <= mdup_pkg::STATUS_CHAN_HI) begin
        // Channel voice message: one copy per selected channel, ascending.
        for (int ch = 0; ch < mdup_pkg::NUM_CHANNELS; ch++) begin
          if (mask_model[ch])
            batch.push_back(make_result({st[7:4], 4'(ch)}, d1, d2, cnt, off));
        end
      end else begin
        batch.push_back(make_result(st, d1, d2, cnt, off));
      end
    end
    if (batch.size() > 0)
      batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i])
      pending_results.push_back(batch[i]);
  endfunction

  // Offer one item, hold it until the block takes it, then idle if the burst is over.
  // Leaves push high when the burst goes on, so the caller must send again or stop.
  task automatic send_message(input logic cmd, input logic [7:0] st, input logic [7:0] d1,
                              input logic [7:0] d2, input logic [1:0] cnt,
                              input logic [15:0] off);
    push          <= 1'b1;
    command       <= cmd;
    status_byte   <= st;
    data_one      <= d1;
    data_two      <= d2;
    byte_count    <= cnt;
    sample_offset <= off;
    do @(posedge clk); while (full);
    predict_duplicates(cmd, st, d1, d2, cnt, off);
    burst_left--;
    if (!sender_steady && burst_left <= 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
  endtask

  // Stop offering, wait for every owed result, then let the queue settle.
  task automatic wait_drained();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the mask register; the block must be idle.
  task automatic write_mask(input logic [15:0] value);
    mask_write   <= 1'b1;
    channel_mask <= value;
    @(posedge clk);
    mask_write    <= 1'b0;
    mask_model    = value;
    applied_model = mdup_pkg::MASK_ALL_ONES;
  endtask

  // Mostly well-formed channel traffic, some system and data bytes, some block
  // starts, and a share of fully random noise.
  task automatic send_random_item();
    int         kind;
    logic       cmd;
    logic [7:0] st;
    logic [1:0] cnt;
    kind = $urandom_range(0, 19);
    cmd  = CMD_MESSAGE;
    cnt  = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : 2'd3;
    if (kind < 12) begin
      st = 8'($urandom_range(mdup_pkg::STATUS_CHAN_LO, mdup_pkg::STATUS_CHAN_HI));
    end else if (kind < 16) begin
      st = $urandom_range(0, 1) ? 8'($urandom_range(8'h00, 8'h7F))
                                : 8'($urandom_range(8'hF0, 8'hFF));
    end else if (kind < 18) begin
      cmd = CMD_BLOCK_START;
      st  = 8'($urandom);
    end else begin
      cmd = 1'($urandom);
      st  = 8'($urandom);
      cnt = 2'($urandom);
    end
    send_message(cmd, st, 8'($urandom), 8'($urandom), cnt, 16'($urandom));
  endtask

  // Non-channel statuses, empty messages and unused bytes pass once.
  task automatic test_pass_through();
    send_message(CMD_MESSAGE, 8'h00, 8'h00, 8'h00, 2'd1, 16'h0000);
    send_message(CMD_MESSAGE, 8'h7F, 8'hFF, 8'hFF, 2'd3, 16'hFFFF);
    send_message(CMD_MESSAGE, 8'hF0, 8'h7E, 8'h55, 2'd2, 16'h1234);
    send_message(CMD_MESSAGE, 8'hF8, 8'hAA, 8'hBB, 2'd1, 16'h8000);
    send_message(CMD_MESSAGE, 8'hFF, 8'hFF, 8'hFF, 2'd0, 16'hFFFF);
    // Channel status with no bytes is an empty message, not a duplicate.
    send_message(CMD_MESSAGE, 8'h80, 8'h12, 8'h34, 2'd0, 16'h0008);
    send_message(CMD_MESSAGE, 8'hF7, 8'h01, 8'h02, 2'd3, 16'h0001);
    wait_drained();
  endtask

  // Channel messages at the status extremes and with short byte counts fan out to all 16.
  task automatic test_channel_duplication();
    send_message(CMD_MESSAGE, 8'h80, 8'h00, 8'h00, 2'd3, 16'h0000);
    send_message(CMD_MESSAGE, 8'hEF, 8'hFF, 8'hFF, 2'd3, 16'hFFFF);
    send_message(CMD_MESSAGE, 8'h9A, 8'h3C, 8'h7F, 2'd1, 16'h0100);
    send_message(CMD_MESSAGE, 8'hC5, 8'h22, 8'h99, 2'd2, 16'h00F0);
    wait_drained();
  endtask

  // Single channels at both ends, a sparse mask, and the zero mask that drops all.
  task automatic test_mask_settings();
    write_mask(16'h0001);
    send_message(CMD_MESSAGE, 8'h95, 8'h40, 8'h7F, 2'd3, 16'h0010);
    wait_drained();
    write_mask(16'h8000);
    send_message(CMD_MESSAGE, 8'hE0, 8'h00, 8'h40, 2'd3, 16'h0020);
    wait_drained();
    write_mask(16'hA5A5);
    send_message(CMD_MESSAGE, 8'hB3, 8'h07, 8'h64, 2'd3, 16'h0030);
    send_message(CMD_MESSAGE, 8'hF2, 8'h11, 8'h22, 2'd3, 16'h0040);
    wait_drained();
    write_mask(16'h0000);
    send_message(CMD_MESSAGE, 8'h90, 8'h3C, 8'h64, 2'd3, 16'h0050);
    send_message(CMD_MESSAGE, 8'hFE, 8'h00, 8'h00, 2'd1, 16'h0060);
    send_message(CMD_MESSAGE, 8'h00, 8'h00, 8'h00, 2'd0, 16'h0070);
    wait_drained();
  endtask

  // Block starts: no change, full panic at zero mask, repeat check, partial panics.
  task automatic test_block_start();
    write_mask(mdup_pkg::MASK_ALL_ONES);
    send_message(CMD_BLOCK_START, 8'h00, 8'h00, 8'h00, 2'd0, 16'h0000);
    wait_drained();
    write_mask(16'h0000);
    send_message(CMD_BLOCK_START, 8'hFF, 8'hFF, 8'hFF, 2'd3, 16'hFFFF);
    send_message(CMD_BLOCK_START, 8'h90, 8'h00, 8'h00, 2'd3, 16'h0000);
    wait_drained();
    write_mask(16'hF0F0);
    send_message(CMD_BLOCK_START, 8'h00, 8'h00, 8'h00, 2'd0, 16'h0000);
    send_message(CMD_MESSAGE, 8'h91, 8'h3C, 8'h50, 2'd3, 16'h0200);
    wait_drained();
    write_mask(16'h00FF);
    send_message(CMD_BLOCK_START, 8'h00, 8'h00, 8'h00, 2'd0, 16'h0000);
    wait_drained();
  endtask

  // Hold the receiver off for a long stretch while the sender keeps pushing
  // full fan-out traffic, so the job queue fills and full stalls the input.
  task automatic test_backpressure();
    write_mask(mdup_pkg::MASK_ALL_ONES);
    hold_req      = 1'b1;
    sender_steady = 1'b1;
    repeat (24)
      send_message(CMD_MESSAGE,
                   8'($urandom_range(mdup_pkg::STATUS_CHAN_LO, mdup_pkg::STATUS_CHAN_HI)),
                   8'($urandom), 8'($urandom), 2'd3, 16'($urandom));
    sender_steady = 1'b0;
    wait_drained();
  endtask

  // Random traffic in phases, each under its own mask, extremes included.
  task automatic test_random_traffic();
    logic [15:0] phase_mask;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: phase_mask = mdup_pkg::MASK_ALL_ONES;
        1: phase_mask = 16'h0000;
        2: phase_mask = 16'h0001 << $urandom_range(0, 15);
        4: phase_mask = 16'h8001;
        default: phase_mask = 16'($urandom);
      endcase
      write_mask(phase_mask);
      sender_steady = (phase == 3);
      repeat (PHASE_ITEMS) send_random_item();
      sender_steady = 1'b0;
      wait_drained();
    end
  endtask

  // Receiver: check each taken result against the oldest expectation, then pick
  // the next pop from the current stall pattern or the long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        seen_result = {out_status, out_data_one, out_data_two, out_byte_count, out_offset, last};
        if (pending_results.size() == 0) begin
          if (failures < MAX_REPORTS)
            $display("unexpected result: status %h data %h %h count %0d offset %h last %b",
                     out_status, out_data_one, out_data_two, out_byte_count, out_offset, last);
          failures++;
        end else begin
          want_result = pending_results.pop_front();
          if (seen_result !== want_result) begin
            if (failures < MAX_REPORTS)
              $display({"result mismatch: expected status %h data %h %h count %0d offset %h ",
                        "last %b, got status %h data %h %h count %0d offset %h last %b"},
                       want_result.status, want_result.data_one, want_result.data_two,
                       want_result.byte_count, want_result.offset, want_result.last,
                       out_status, out_data_one, out_data_two, out_byte_count,
                       out_offset, last);
            failures++;
          end
        end
      end
      if (hold_req) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_req  = 1'b0;
      end
      if (pop_mode_left <= 0) begin
        pop_mode      = $urandom_range(0, 3);
        pop_mode_left = $urandom_range(20, 80);
      end
      pop_mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        case (pop_mode)
          0: pop <= 1'b1;
          1: pop <= 1'($urandom);
          2: pop <= ($urandom_range(0, 3) == 0);
          default: pop <= ((pop_mode_left % 8) < 5);
        endcase
      end
    end
  end

  // Watchdog: end the run if no transaction happens for too long.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || mask_write)
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("midi_channel_duplicator_test NOT OK");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_pass_through();
    test_channel_duplication();
    test_mask_settings();
    test_block_start();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    if (failures == 0)
      $display("midi_channel_duplicator_test OK");
    else
      $display("midi_channel_duplicator_test NOT OK");
    $finish;
  end

endmodule

FILE: midi_channel_duplicator.f
+incdir+rtl
rtl/mdup_pkg.sv
rtl/mdup_front.sv
rtl/mdup_job_queue.sv
rtl/mdup_back.sv
rtl/midi_channel_duplicator.sv
bench/midi_channel_duplicator_test.sv
